// ===== rtl/bhdc_pkg.sv =====
// bhdc_pkg: shared types, register codes, reset values and lookup tables
// of the hall drive controller. No dependencies.
`timescale 1ns / 1ps

package bhdc_pkg;

  localparam int unsigned DUTY_MAX = 52429;
  localparam int unsigned INTEG_MAX = 52428800;

  localparam logic [15:0] KP_POS_RST = 16'd19661;
  localparam logic [15:0] KD_POS_RST = 16'd3932;
  localparam logic [15:0] KP_VEL_RST = 16'd13107;
  localparam logic [15:0] KI_VEL_RST = 16'd328;

  // mode flag bit positions
  localparam int MODE_VEL  = 0;
  localparam int MODE_POS  = 1;
  localparam int MODE_SPIN = 2;

  typedef enum logic [2:0] {
    REG_ORIGIN = 3'd0,
    REG_MODE   = 3'd1,
    REG_TVEL   = 3'd2,
    REG_TPOS   = 3'd3,
    REG_KP_POS = 3'd4,
    REG_KD_POS = 3'd5,
    REG_KP_VEL = 3'd6,
    REG_KI_VEL = 3'd7
  } reg_idx_t;

  // classified request handed from front to back
  typedef struct packed {
    logic       tick;
    logic       hall_ok;
    logic [2:0] rotor;
  } item_t;

  typedef struct packed {
    logic [2:0]  origin;
    logic [2:0]  mode;
    logic [31:0] tvel;
    logic [31:0] tpos;
    logic [15:0] kp_pos;
    logic [15:0] kd_pos;
    logic [15:0] kp_vel;
    logic [15:0] ki_vel;
  } cfg_t;

  function automatic logic [2:0] hall_decode(input logic [2:0] hall);
    logic [2:0] rotor;
    case (hall)
      3'd0:    rotor = 3'd7;
      3'd1:    rotor = 3'd5;
      3'd2:    rotor = 3'd3;
      3'd3:    rotor = 3'd4;
      3'd4:    rotor = 3'd1;
      3'd5:    rotor = 3'd0;
      3'd6:    rotor = 3'd2;
      default: rotor = 3'd7;
    endcase
    return rotor;
  endfunction

  function automatic logic [5:0] drive_lookup(input logic [2:0] idx);
    logic [5:0] word;
    case (idx)
      3'd0:    word = 6'h12;
      3'd1:    word = 6'h18;
      3'd2:    word = 6'h09;
      3'd3:    word = 6'h21;
      3'd4:    word = 6'h24;
      3'd5:    word = 6'h06;
      default: word = 6'h00;
    endcase
    return word;
  endfunction

endpackage

// ===== rtl/bhdc_front.sv =====
// bhdc_front: accepts input requests, decodes hall levels to a rotor state
// and holds classified requests in a two-entry queue. Depends on bhdc_pkg.
`timescale 1ns / 1ps

module bhdc_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            in_kind,
  input  logic [2:0]      in_hall_bits,
  output logic            q_valid,
  output bhdc_pkg::item_t q_item,
  input  logic            q_pop
);
  import bhdc_pkg::*;

  item_t      slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic [1:0] count_nxt;
  logic       push;
  item_t      cls;

  always_comb begin
    cls.tick    = in_kind;
    cls.rotor   = hall_decode(in_hall_bits);
    cls.hall_ok = (cls.rotor < 3'd6);
  end

  assign in_ready  = (count_r != 2'd2);
  assign push      = in_valid && in_ready;
  assign q_valid   = (count_r != 2'd0);
  assign q_item    = slot_r[rd_ptr_r];
  assign count_nxt = count_r + {1'b0, push} - {1'b0, q_pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (q_pop) rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= cls;
  end

endmodule

// ===== rtl/bhdc_back.sv =====
// bhdc_back: executes queued requests; commutation and position count for
// hall requests, a multi-step sequencer for control ticks. Depends on bhdc_pkg.
`timescale 1ns / 1ps

module bhdc_back #(
  parameter int TICKS_PER_SECOND = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  bhdc_pkg::item_t    q_item,
  output logic               q_pop,
  input  bhdc_pkg::cfg_t     cfg,
  input  logic               clear_follow,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [5:0]         out_drive_word,
  output logic [15:0]        out_duty,
  output logic               out_forward,
  output logic signed [31:0] out_position,
  output logic signed [31:0] out_velocity
);
  import bhdc_pkg::*;

  localparam int TW = $clog2(TICKS_PER_SECOND + 1);
  localparam int TL = $clog2(TICKS_PER_SECOND);
  localparam int PW = 33 + TW;
  localparam logic [TW-1:0] TICKS = TW'(TICKS_PER_SECOND);
  localparam logic [63:0] RECIP_T_FULL =
    ((64'd1 << (32 + TL)) + 64'(TICKS_PER_SECOND) - 64'd1) / 64'(TICKS_PER_SECOND);
  localparam logic [32:0] RECIP_T = RECIP_T_FULL[32:0];
  localparam logic [31:0] RECIP_3 = 32'd2863311531;

  typedef enum logic [2:0] {
    ST_IDLE, ST_VDIV, ST_VFIN, ST_PFIN, ST_MUL, ST_INT, ST_GAIN, ST_DONE
  } state_t;

  function automatic logic [5:0] commute(input logic [2:0] rotor, input logic lead,
                                         input logic [2:0] origin);
    logic [4:0] s;
    s = {2'b00, rotor} + 5'd12 - {2'b00, origin} + (lead ? 5'd2 : 5'd4);
    if (s >= 5'd12) s = s - 5'd12;
    if (s >= 5'd6) s = s - 5'd6;
    return drive_lookup(s[2:0]);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
    logic signed [31:0] r;
    if (v > 49'sd2147483647) r = 32'sh7fffffff;
    else if (v < -49'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  // |sum| / 65536, capped at the duty limit
  function automatic logic [15:0] finish(input logic signed [51:0] s);
    logic [51:0] mag;
    logic [35:0] sh;
    mag = s[51] ? (~s + 52'd1) : s;
    sh  = mag[51:16];
    return (sh > 36'(DUTY_MAX)) ? 16'(DUTY_MAX) : sh[15:0];
  endfunction

  state_t             state_r;
  logic [2:0]         last_rotor_r;
  logic signed [31:0] pos_r;
  logic [31:0]        prev_tick_r;
  logic signed [31:0] meas_r;
  logic signed [31:0] ppe_r;
  logic signed [31:0] vint_r;
  logic [15:0]        duty_r;
  logic               lead_r;
  logic [1:0]         follow_r;

  logic signed [PW-1:0] p_r;
  logic                 vneg_r;
  logic                 vbig_r;
  logic                 pneg_r;
  logic [31:0]          a3_r;
  logic [63:0]          prod3_r;
  logic signed [31:0]   er_r;
  logic signed [31:0]   es_r;
  logic                 tzero_r;
  logic                 lead_base_r;
  logic [1:0]           follow_new_r;
  logic signed [48:0]   mp_r;
  logic signed [49:0]   md_r;
  logic [64:0]          pt_r;
  logic signed [31:0]   vint_new_r;
  logic signed [48:0]   mvp_r;
  logic signed [48:0]   mvi_r;

  logic               out_valid_r;
  logic [5:0]         out_word_r;
  logic [15:0]        out_duty_r;
  logic               out_fwd_r;
  logic signed [31:0] out_pos_r;
  logic signed [31:0] out_vel_r;

  logic               out_free;
  logic               out_load;
  logic signed [3:0]  hall_diff;
  logic signed [31:0] pos_after;
  logic [31:0]        delta;
  logic signed [PW-1:0] vel_prod;
  logic [PW-1:0]      p_abs;
  logic               p_big;
  logic [31:0]        a3_vel;
  logic [31:0]        pos_abs;
  logic [30:0]        q3;
  logic [1:0]         r3;
  logic [14:0]        frac3;
  logic [45:0]        mag3;
  logic signed [31:0] meas_calc;
  logic signed [48:0] rotq;
  logic signed [48:0] tpos_ext;
  logic signed [31:0] er_calc;
  logic [31:0]        tmag;
  logic signed [48:0] eff_ext;
  logic signed [48:0] meas_ext;
  logic signed [31:0] es_calc;
  logic               lead_base;
  logic signed [32:0] pe_diff;
  logic [31:0]        es_abs;
  logic [64:0]        pt_sh;
  logic [31:0]        qt;
  logic signed [33:0] qt_s;
  logic signed [33:0] integ_sum;
  logic signed [31:0] integ_clamp;
  logic signed [50:0] sum_p;
  logic signed [49:0] sum_v;
  logic [15:0]        duty_v;
  logic [15:0]        duty_p;
  logic [15:0]        torque;
  logic               pos_run;
  logic               vel_run;
  logic               lead_new;

  assign out_free = !out_valid_r || out_ready;
  assign q_pop    = (state_r == ST_IDLE) && q_valid && (q_item.tick || out_free);
  assign out_load = (q_pop && !q_item.tick) || ((state_r == ST_DONE) && out_free);

  always_comb begin
    // hall step, wrapping between states 5 and 0
    hall_diff = $signed({1'b0, q_item.rotor}) - $signed({1'b0, last_rotor_r});
    if (hall_diff == 4'sd5) hall_diff = -4'sd1;
    else if (hall_diff == -4'sd5) hall_diff = 4'sd1;
    pos_after = pos_r + {{28{hall_diff[3]}}, hall_diff};

    delta    = pos_r - prev_tick_r;
    vel_prod = $signed(delta) * $signed({1'b0, TICKS});
    p_abs    = p_r[PW-1] ? (~p_r + PW'(1)) : p_r;
    p_big    = (p_abs >= PW'(524288));
    a3_vel   = p_big ? 32'd0 : {13'd0, p_abs[18:0]};
    pos_abs  = pos_r[31] ? (~pos_r + 32'd1) : pos_r;

    // shared divide by three: floor(a * 32768 / 3)
    q3    = prod3_r[63:33];
    r3    = 2'(a3_r - 32'(q3) * 32'd3);
    frac3 = (r3 == 2'd1) ? 15'd10922 : ((r3 == 2'd2) ? 15'd21845 : 15'd0);
    mag3  = {q3, frac3};

    if (vbig_r) meas_calc = vneg_r ? 32'sh80000000 : 32'sh7fffffff;
    else if (!vneg_r) meas_calc = (mag3 > 46'd2147483647) ? 32'sh7fffffff : mag3[31:0];
    else meas_calc = (mag3 > 46'd2147483648) ? 32'sh80000000 : (~mag3[31:0] + 32'd1);

    rotq     = pneg_r ? -$signed({3'b000, mag3}) : $signed({3'b000, mag3});
    tpos_ext = {cfg.tpos[31], cfg.tpos, 16'h0000};
    er_calc  = sat32(tpos_ext - rotq);

    if (cfg.tvel[31]) tmag = (cfg.tvel == 32'h80000000) ? 32'h7fffffff : (~cfg.tvel + 32'd1);
    else tmag = cfg.tvel;
    eff_ext  = meas_r[31] ? -$signed({17'd0, tmag}) : $signed({17'd0, tmag});
    meas_ext = {{17{meas_r[31]}}, meas_r};
    es_calc  = sat32(eff_ext - meas_ext);
    case (follow_r)
      2'd1:    lead_base = 1'b1;
      2'd2:    lead_base = 1'b0;
      default: lead_base = !cfg.tvel[31] && (cfg.tvel != 32'd0);
    endcase

    pe_diff = {er_r[31], er_r} - {ppe_r[31], ppe_r};
    es_abs  = es_r[31] ? (~es_r + 32'd1) : es_r;

    pt_sh = pt_r >> (32 + TL);
    qt    = pt_sh[31:0];
    qt_s  = es_r[31] ? -$signed({2'b00, qt}) : $signed({2'b00, qt});
    integ_sum = $signed({{2{vint_r[31]}}, vint_r}) + qt_s;
    if (integ_sum > $signed(34'(INTEG_MAX))) integ_clamp = 32'(INTEG_MAX);
    else if (integ_sum < -$signed(34'(INTEG_MAX))) integ_clamp = -$signed(32'(INTEG_MAX));
    else integ_clamp = integ_sum[31:0];

    sum_p  = mp_r + md_r;
    sum_v  = mvp_r + mvi_r;
    duty_v = tzero_r ? 16'd0 : finish({{2{sum_v[49]}}, sum_v});
    duty_p = finish({sum_p[50], sum_p});

    vel_run = cfg.mode[MODE_VEL];
    pos_run = cfg.mode[MODE_POS] && !cfg.mode[MODE_SPIN];
    if (cfg.mode[MODE_SPIN]) begin
      torque = vel_run ? duty_v : 16'(DUTY_MAX);
    end else if (cfg.mode[MODE_VEL] && cfg.mode[MODE_POS]) begin
      if (!meas_r[31]) torque = (duty_v < duty_p) ? duty_v : duty_p;
      else torque = (duty_v > duty_p) ? duty_v : duty_p;
    end else if (cfg.mode[MODE_VEL]) begin
      torque = duty_v;
    end else if (cfg.mode[MODE_POS]) begin
      torque = duty_p;
    end else begin
      torque = duty_r;
    end

    if (pos_run) lead_new = !sum_p[50];
    else if (vel_run && !tzero_r) lead_new = lead_base_r ^ sum_v[49];
    else lead_new = lead_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      last_rotor_r <= 3'd0;
      pos_r        <= 32'sd0;
      prev_tick_r  <= 32'd0;
      meas_r       <= 32'sd0;
      ppe_r        <= 32'sd0;
      vint_r       <= 32'sd0;
      duty_r       <= 16'd0;
      lead_r       <= 1'b0;
      follow_r     <= 2'd0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_load) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (q_pop && !q_item.tick) begin
            out_duty_r  <= duty_r;
            out_fwd_r   <= lead_r;
            out_vel_r   <= meas_r;
            if (q_item.hall_ok) begin
              pos_r        <= pos_after;
              last_rotor_r <= q_item.rotor;
              out_pos_r    <= pos_after;
              out_word_r   <= commute(q_item.rotor, lead_r, cfg.origin);
            end else begin
              out_pos_r  <= pos_r;
              out_word_r <= 6'h00;
            end
          end else if (q_pop) begin
            p_r         <= vel_prod;
            prev_tick_r <= pos_r;
            state_r     <= ST_VDIV;
          end
        end
        ST_VDIV: begin
          vneg_r  <= p_r[PW-1];
          vbig_r  <= p_big;
          a3_r    <= a3_vel;
          prod3_r <= 64'(a3_vel) * 64'(RECIP_3);
          state_r <= ST_VFIN;
        end
        ST_VFIN: begin
          meas_r  <= meas_calc;
          pneg_r  <= pos_r[31];
          a3_r    <= pos_abs;
          prod3_r <= 64'(pos_abs) * 64'(RECIP_3);
          state_r <= ST_PFIN;
        end
        ST_PFIN: begin
          er_r         <= er_calc;
          es_r         <= es_calc;
          tzero_r      <= (cfg.tvel == 32'd0);
          lead_base_r  <= lead_base;
          follow_new_r <= meas_r[31] ? 2'd2 : 2'd1;
          state_r      <= ST_MUL;
        end
        ST_MUL: begin
          mp_r    <= $signed({1'b0, cfg.kp_pos}) * er_r;
          md_r    <= $signed({1'b0, cfg.kd_pos}) * pe_diff;
          pt_r    <= 65'(es_abs) * 65'(RECIP_T);
          state_r <= ST_INT;
        end
        ST_INT: begin
          vint_new_r <= integ_clamp;
          state_r    <= ST_GAIN;
        end
        ST_GAIN: begin
          mvp_r   <= $signed({1'b0, cfg.kp_vel}) * es_r;
          mvi_r   <= $signed({1'b0, cfg.ki_vel}) * vint_new_r;
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            duty_r <= torque;
            lead_r <= lead_new;
            if (pos_run) ppe_r <= er_r;
            if (vel_run && !tzero_r) begin
              if (!clear_follow) follow_r <= follow_new_r;
              vint_r <= vint_new_r;
            end
            out_word_r  <= commute(last_rotor_r, lead_new, cfg.origin);
            out_duty_r  <= torque;
            out_fwd_r   <= lead_new;
            out_pos_r   <= pos_r;
            out_vel_r   <= meas_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
      // target speed rewritten: go back to its configured sign
      if (clear_follow) follow_r <= 2'd0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_drive_word = out_word_r;
  assign out_duty       = out_duty_r;
  assign out_forward    = out_fwd_r;
  assign out_position   = out_pos_r;
  assign out_velocity   = out_vel_r;

endmodule

// ===== rtl/bldc_hall_drive_controller.sv =====
// bldc_hall_drive_controller: top level with the configuration registers,
// the request front end and the execution back end. Depends on bhdc_pkg,
// bhdc_front and bhdc_back.
`timescale 1ns / 1ps

// Brushless motor controller driven by two kinds of request: a hall request
// (in_kind 0) updates the rotor state, the position count in sixths of a turn
// and returns the phase drive word; a tick request (in_kind 1) marks one
// control period of 1/TICKS_PER_SECOND s, measures speed, runs PI velocity
// and/or PD position control by mode_flags and returns the new duty (Q0.16,
// capped at 0.8) and direction. Each request yields exactly one result, in
// order. The front end takes one request per cycle into a two-entry queue
// while not full; the back end handles a hall request from idle and a tick
// in a sequencer around one shared divide-by-three and the gain multipliers.
// A tick may start while a result waits in the output register. The user
// makes configuration writes (cfg_ready is always high) while the block is
// idle, not enforced here; writing the target speed resets sign following.
module bldc_hall_drive_controller #(
  parameter int TICKS_PER_SECOND = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_kind,
  input  logic [2:0]         in_hall_bits,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [5:0]         out_drive_word,
  output logic [15:0]        out_duty,
  output logic               out_forward,
  output logic signed [31:0] out_position,
  output logic signed [31:0] out_velocity,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import bhdc_pkg::*;

  cfg_t  cfg_r;
  logic  cfg_we;
  logic  clear_follow;
  logic  q_valid;
  item_t q_item;
  logic  q_pop;

  assign cfg_ready    = 1'b1;
  assign cfg_we       = cfg_valid && cfg_ready;
  assign clear_follow = cfg_we && (reg_idx_t'(cfg_index) == REG_TVEL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin <= 3'd0;
      cfg_r.mode   <= 3'd0;
      cfg_r.tvel   <= 32'd0;
      cfg_r.tpos   <= 32'd0;
      cfg_r.kp_pos <= KP_POS_RST;
      cfg_r.kd_pos <= KD_POS_RST;
      cfg_r.kp_vel <= KP_VEL_RST;
      cfg_r.ki_vel <= KI_VEL_RST;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_ORIGIN: cfg_r.origin <= cfg_data[2:0];
        REG_MODE:   cfg_r.mode   <= cfg_data[2:0];
        REG_TVEL:   cfg_r.tvel   <= cfg_data;
        REG_TPOS:   cfg_r.tpos   <= cfg_data;
        REG_KP_POS: cfg_r.kp_pos <= cfg_data[15:0];
        REG_KD_POS: cfg_r.kd_pos <= cfg_data[15:0];
        REG_KP_VEL: cfg_r.kp_vel <= cfg_data[15:0];
        REG_KI_VEL: cfg_r.ki_vel <= cfg_data[15:0];
        default:    cfg_r.mode   <= cfg_r.mode;
      endcase
    end
  end

  bhdc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_kind      (in_kind),
    .in_hall_bits (in_hall_bits),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop)
  );

  bhdc_back #(
    .TICKS_PER_SECOND (TICKS_PER_SECOND)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop),
    .cfg            (cfg_r),
    .clear_follow   (clear_follow),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_drive_word (out_drive_word),
    .out_duty       (out_duty),
    .out_forward    (out_forward),
    .out_position   (out_position),
    .out_velocity   (out_velocity)
  );

endmodule

// ===== bench/tb_top.sv =====
// tb_top: self-checking bench for the hall commutation and speed/position
// controller. Needs bhdc_pkg and bldc_hall_drive_controller from rtl/.
`timescale 1ns / 1ps

module tb_top;
  import bhdc_pkg::*;

  localparam int TICKS = 10;
  localparam bit KIND_HALL = 1'b0;
  localparam bit KIND_TICK = 1'b1;
  localparam int STALL_LIMIT = 3000;
  localparam int TAIL_CYCLES = 30;
  localparam int MAX_PRINTS = 40;
  localparam longint DUTY_CAP = DUTY_MAX;
  localparam longint INTEG_CAP = INTEG_MAX;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;

  typedef enum logic [1:0] {FOLLOW_CFG, FOLLOW_POS, FOLLOW_NEG} follow_t;

  typedef struct packed {
    logic [5:0]         drive;
    logic [15:0]        duty;
    logic               fwd;
    logic signed [31:0] pos;
    logic signed [31:0] vel;
  } status_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid, in_ready, in_kind;
  logic [2:0] in_hall_bits;
  logic out_valid, out_ready;
  logic [5:0] out_drive_word;
  logic [15:0] out_duty;
  logic out_forward;
  logic signed [31:0] out_position, out_velocity;
  logic cfg_valid, cfg_ready;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  bldc_hall_drive_controller #(.TICKS_PER_SECOND(TICKS)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_kind(in_kind), .in_hall_bits(in_hall_bits),
    .out_valid(out_valid), .out_ready(out_ready), .out_drive_word(out_drive_word),
    .out_duty(out_duty), .out_forward(out_forward), .out_position(out_position),
    .out_velocity(out_velocity),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // controller registers as the bench believes them
  logic [2:0]  m_origin = 3'd0;
  logic [2:0]  m_mode = 3'd0;
  int          m_tvel = 0;
  int          m_tpos = 0;
  logic [15:0] m_kp_pos = KP_POS_RST;
  logic [15:0] m_kd_pos = KD_POS_RST;
  logic [15:0] m_kp_vel = KP_VEL_RST;
  logic [15:0] m_ki_vel = KI_VEL_RST;

  // controller state
  logic [2:0]  rotor_now = 3'd0;
  int          pos_count = 0;
  int          pos_at_tick = 0;
  int          speed = 0;
  int          pos_err_prev = 0;
  int          vel_integ = 0;
  logic [15:0] duty_now = 16'd0;
  bit          lead_fwd = 1'b0;
  follow_t     sign_follow = FOLLOW_CFG;

  status_t drive_status_q[$];

  int mismatches = 0;
  int items_sent = 0;
  int ticks_sent = 0;
  int cfg_writes = 0;
  int results_seen = 0;
  int quiet_cycles = 0;

  bit in_offer = 1'b0;
  bit cfg_offer = 1'b0;
  bit steady = 1'b0;
  int burst_left = 0;

  int rx_hold_request = 0;
  int rx_hold = 0;
  int rx_style = 0;
  int rx_left = 0;
  int rx_count = 0;

  function automatic logic [2:0] rotor_of_hall(logic [2:0] hall);
    case (hall)
      3'd1:    return 3'd5;
      3'd2:    return 3'd3;
      3'd3:    return 3'd4;
      3'd4:    return 3'd1;
      3'd5:    return 3'd0;
      3'd6:    return 3'd2;
      default: return 3'd7;
    endcase
  endfunction

  function automatic logic [2:0] hall_of_rotor(int rotor);
    case (rotor)
      0:       return 3'd5;
      1:       return 3'd4;
      2:       return 3'd6;
      3:       return 3'd2;
      4:       return 3'd3;
      default: return 3'd1;
    endcase
  endfunction

  function automatic logic [5:0] phase_word(int idx);
    case (idx)
      0:       return 6'h12;
      1:       return 6'h18;
      2:       return 6'h09;
      3:       return 6'h21;
      4:       return 6'h24;
      default: return 6'h06;
    endcase
  endfunction

  function automatic longint clamp32(longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  // origin 6 and 7 go into the sum unreduced
  function automatic logic [5:0] commutate(logic [2:0] rotor);
    int idx;
    idx = (int'(rotor) + 12 - int'(m_origin) + (lead_fwd ? 2 : 4)) % 6;
    return phase_word(idx);
  endfunction

  function automatic longint duty_from_sum(longint sum);
    longint d;
    d = sum / 65536;
    if (d < 0) d = -d;
    return (d > DUTY_CAP) ? DUTY_CAP : d;
  endfunction

  function automatic longint position_pd();
    longint rot, er, de, sum;
    rot = longint'(pos_count) * 65536 / 6;
    er = clamp32(longint'(m_tpos) * 65536 - rot);
    de = er - longint'(pos_err_prev);
    pos_err_prev = int'(er);
    sum = longint'(m_kp_pos) * er + longint'(m_kd_pos) * de;
    lead_fwd = (sum >= 0);
    return duty_from_sum(sum);
  endfunction

  function automatic longint velocity_pi();
    longint t, mag, eff, es, integ, sum, meas;
    t = m_tvel;
    meas = speed;
    // zero target leaves every piece of state alone
    if (t == 0) return 0;
    mag = (t < 0) ? -t : t;
    if (mag > S32_MAX) mag = S32_MAX;
    if (sign_follow == FOLLOW_POS) t = mag;
    else if (sign_follow == FOLLOW_NEG) t = -mag;
    lead_fwd = (t > 0);
    eff = (meas < 0) ? -mag : mag;
    sign_follow = (meas < 0) ? FOLLOW_NEG : FOLLOW_POS;
    es = clamp32(eff - meas);
    integ = longint'(vel_integ) + es / TICKS;
    if (integ > INTEG_CAP) integ = INTEG_CAP;
    if (integ < -INTEG_CAP) integ = -INTEG_CAP;
    vel_integ = int'(integ);
    sum = longint'(m_kp_vel) * es + longint'(m_ki_vel) * integ;
    if (sum < 0) lead_fwd = !lead_fwd;
    return duty_from_sum(sum);
  endfunction

  function automatic status_t next_drive_status(bit kind, logic [2:0] hall);
    status_t r;
    logic [2:0] rotor;
    int diff, d32;
    longint delta, torque, v, p;
    bit vel_on, pos_on, spin_on;
    if (kind == KIND_HALL) begin
      rotor = rotor_of_hall(hall);
      if (rotor < 6) begin
        diff = int'(rotor) - int'(rotor_now);
        if (diff == 5) diff = -1;
        else if (diff == -5) diff = 1;
        pos_count += diff;
        rotor_now = rotor;
        r.drive = commutate(rotor);
      end else begin
        r.drive = '0;
      end
    end else begin
      vel_on = m_mode[MODE_VEL];
      pos_on = m_mode[MODE_POS];
      spin_on = m_mode[MODE_SPIN];
      d32 = pos_count - pos_at_tick;
      delta = d32;
      speed = int'(clamp32(delta * 65536 * TICKS / 6));
      pos_at_tick = pos_count;
      torque = duty_now;
      if (spin_on) begin
        torque = vel_on ? velocity_pi() : DUTY_CAP;
      end else if (vel_on && !pos_on) begin
        torque = velocity_pi();
      end else if (pos_on && !vel_on) begin
        torque = position_pd();
      end else if (vel_on && pos_on) begin
        v = velocity_pi();
        p = position_pd();
        if (speed >= 0) torque = (v < p) ? v : p;
        else torque = (v > p) ? v : p;
      end
      duty_now = torque[15:0];
      r.drive = commutate(rotor_now);
    end
    r.duty = duty_now;
    r.fwd = lead_fwd;
    r.pos = pos_count;
    r.vel = speed;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatches < MAX_PRINTS) $display("[%0t] %s", $time, msg);
    mismatches++;
  endtask

  task automatic drop_request();
    if (in_offer) begin
      in_valid <= 1'b0;
      in_offer = 1'b0;
    end
  endtask

  task automatic drop_config();
    if (cfg_offer) begin
      cfg_valid <= 1'b0;
      cfg_offer = 1'b0;
    end
  endtask

  task automatic send_request(bit kind, logic [2:0] hall);
    int gap;
    drop_config();
    if (!steady && burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = $urandom_range(0, 12);
      if (gap != 0) begin
        drop_request();
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_hall_bits <= hall;
    in_offer = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    drive_status_q.push_back(next_drive_status(kind, hall));
    items_sent++;
    if (kind == KIND_TICK) ticks_sent++;
    if (burst_left != 0) burst_left--;
  endtask

  // only called while the block is idle
  task automatic write_reg(reg_idx_t idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    cfg_offer = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_ORIGIN: m_origin = data[2:0];
      REG_MODE:   m_mode = data[2:0];
      REG_TVEL: begin
        m_tvel = data;
        sign_follow = FOLLOW_CFG;
      end
      REG_TPOS:   m_tpos = data;
      REG_KP_POS: m_kp_pos = data[15:0];
      REG_KD_POS: m_kd_pos = data[15:0];
      REG_KP_VEL: m_kp_vel = data[15:0];
      default:    m_ki_vel = data[15:0];
    endcase
    cfg_writes++;
  endtask

  task automatic settle();
    drop_request();
    drop_config();
    @(posedge clk);
    while (drive_status_q.size() != 0) @(posedge clk);
  endtask

  task automatic spin_steps(int dir, int count);
    int i;
    for (i = 0; i < count; i++)
      send_request(KIND_HALL, hall_of_rotor((int'(rotor_now) + dir + 6) % 6));
  endtask

  function automatic logic [31:0] pick_gain(logic [15:0] dflt);
    case ($urandom_range(0, 3))
      0:       return {16'd0, dflt};
      1:       return $urandom_range(0, 4000);
      default: return $urandom();
    endcase
  endfunction

  task automatic test_hall_patterns();
    int code;
    // every code, dead patterns and rotor jumps included
    for (code = 0; code < 8; code++) send_request(KIND_HALL, code[2:0]);
    // across the 5/0 seam in both directions
    send_request(KIND_HALL, hall_of_rotor(5));
    send_request(KIND_HALL, hall_of_rotor(0));
    send_request(KIND_HALL, hall_of_rotor(5));
    send_request(KIND_TICK, 3'd0);
  endtask

  task automatic test_control_modes();
    int m;
    settle();
    write_reg(REG_ORIGIN, 32'd7);
    write_reg(REG_TVEL, 32'h7fffffff);
    write_reg(REG_TPOS, 32'h80000000);
    write_reg(REG_KP_POS, 32'hffff);
    write_reg(REG_KD_POS, 32'hffff);
    write_reg(REG_KP_VEL, 32'hffff);
    write_reg(REG_KI_VEL, 32'hffff);
    for (m = 0; m < 8; m++) begin
      settle();
      write_reg(REG_MODE, m);
      send_request(KIND_TICK, 3'($urandom_range(0, 7)));
    end
    settle();
    write_reg(REG_ORIGIN, 32'd6);
    write_reg(REG_TVEL, 32'h80000000);
    write_reg(REG_TPOS, 32'h7fffffff);
    write_reg(REG_KP_POS, 32'd0);
    write_reg(REG_KD_POS, 32'd0);
    write_reg(REG_KP_VEL, 32'd0);
    write_reg(REG_KI_VEL, 32'd0);
    write_reg(REG_MODE, 32'd3);
    send_request(KIND_TICK, 3'd7);
    settle();
    write_reg(REG_MODE, 32'd5);
    send_request(KIND_TICK, 3'd0);
    // zero target speed under velocity control
    settle();
    write_reg(REG_TVEL, 32'd0);
    write_reg(REG_MODE, 32'd1);
    send_request(KIND_TICK, 3'd5);
  endtask

  // a long run of steps in one period gives a large speed reading
  task automatic test_fast_spin();
    settle();
    write_reg(REG_ORIGIN, 32'd0);
    write_reg(REG_MODE, 32'd3);
    write_reg(REG_TVEL, 32'd5 << 16);
    write_reg(REG_TPOS, 32'd0);
    write_reg(REG_KP_POS, {16'd0, KP_POS_RST});
    write_reg(REG_KD_POS, {16'd0, KD_POS_RST});
    write_reg(REG_KP_VEL, {16'd0, KP_VEL_RST});
    write_reg(REG_KI_VEL, {16'd0, KI_VEL_RST});
    steady = 1'b1;
    send_request(KIND_TICK, 3'd0);
    spin_steps(1, 100);
    send_request(KIND_TICK, 3'd0);
    spin_steps(-1, 100);
    send_request(KIND_TICK, 3'd0);
    steady = 1'b0;
  endtask

  task automatic test_backpressure();
    settle();
    rx_hold_request = 300;
    steady = 1'b1;
    repeat (40) send_request(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
    steady = 1'b0;
  endtask

  task automatic test_random_phases();
    int phase, n, steps, i, dir;
    logic [31:0] tv, tp;
    dir = 1;
    for (phase = 0; phase < 10; phase++) begin
      settle();
      // narrow registers get junk in the unused upper bits
      write_reg(REG_ORIGIN, $urandom());
      write_reg(REG_MODE, $urandom());
      if ($urandom_range(0, 1) != 0) begin
        case ($urandom_range(0, 7))
          0:       tv = 32'd0;
          1:       tv = 32'h7fffffff;
          2:       tv = 32'h80000000;
          3:       tv = $urandom();
          default: begin
            tv = $urandom_range(1, 12 << 16);
            if ($urandom_range(0, 1) != 0) tv = -tv;
          end
        endcase
        write_reg(REG_TVEL, tv);
      end
      if ($urandom_range(0, 1) != 0) begin
        tp = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 60) - 30;
        write_reg(REG_TPOS, tp);
      end
      write_reg(REG_KP_POS, pick_gain(KP_POS_RST));
      write_reg(REG_KD_POS, pick_gain(KD_POS_RST));
      write_reg(REG_KP_VEL, pick_gain(KP_VEL_RST));
      write_reg(REG_KI_VEL, pick_gain(KI_VEL_RST));
      n = 0;
      while (n < 150) begin
        if ($urandom_range(0, 4) == 0) dir = -dir;
        steps = $urandom_range(0, 14);
        for (i = 0; i < steps; i++) begin
          // now and then a dead code or a skipped sector
          if ($urandom_range(0, 24) == 0) send_request(KIND_HALL, 3'($urandom_range(0, 7)));
          else spin_steps(dir, 1);
        end
        send_request(KIND_TICK, 3'($urandom_range(0, 7)));
        n += steps + 1;
      end
    end
  endtask

  always @(posedge clk) begin : check_results
    status_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (drive_status_q.size() == 0) begin
        report_mismatch($sformatf("result with no request outstanding: drive %h duty %0d",
                                  out_drive_word, out_duty));
      end else begin
        want = drive_status_q.pop_front();
        if (out_drive_word !== want.drive)
          report_mismatch($sformatf("drive_word got %h want %h", out_drive_word, want.drive));
        if (out_duty !== want.duty)
          report_mismatch($sformatf("duty got %0d want %0d", out_duty, want.duty));
        if (out_forward !== want.fwd)
          report_mismatch($sformatf("forward got %b want %b", out_forward, want.fwd));
        if (out_position !== want.pos)
          report_mismatch($sformatf("position got %0d want %0d", out_position, want.pos));
        if (out_velocity !== want.vel)
          report_mismatch($sformatf("velocity got %0d want %0d", out_velocity, want.vel));
      end
    end
  end

  always @(posedge clk) begin : receiver
    if (rx_hold_request != 0) begin
      rx_hold = rx_hold_request;
      rx_hold_request = 0;
    end
    if (rx_hold != 0) begin
      rx_hold--;
      out_ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_style = $urandom_range(0, 3);
        rx_left = $urandom_range(16, 160);
      end
      rx_left--;
      rx_count++;
      case (rx_style)
        0:       out_ready <= 1'b1;
        1:       out_ready <= ($urandom_range(0, 3) != 0);
        2:       out_ready <= ($urandom_range(0, 2) == 0);
        default: out_ready <= ((rx_count % 5) < 2);
      endcase
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("[%0t] no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("bldc_hall_drive_controller test failed");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_kind = 1'b0;
    in_hall_bits = 3'd0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_ORIGIN;
    cfg_data = 32'd0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_hall_patterns();
    test_control_modes();
    test_fast_spin();
    test_backpressure();
    test_random_phases();
    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (drive_status_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", drive_status_q.size()));
    $display("covered %0d requests (%0d ticks) and %0d register writes: hall codes, all modes,",
             items_sent, ticks_sent, cfg_writes);
    $display("fast spins, a long output stall and randomized phases; %0d results, %0d bad",
             results_seen, mismatches);
    if (mismatches == 0) begin
      $display("bldc_hall_drive_controller test passed");
    end else begin
      $display("bldc_hall_drive_controller test failed");
    end
    $finish;
  end

endmodule
